/* hdl/kvst_pkg.sv */
// Shared types and constants for the key/value slot table.
// Used by kvst_scan, key_value_slot_table_top and the testbench; depends on nothing.
`default_nettype none

package kvst_pkg;

   // Field widths of one request and one response beat.
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CMD_W   = 2;

   // Command codes carried in req_tuser.
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_POP    = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   // Control from the sequencer to the scan unit.
   typedef struct packed {
      logic clear;   // restart the accumulators for a new command
      logic step;    // a slot's key and occupied bit are presented this cycle
   } scan_ctl_type;

endpackage : kvst_pkg

`default_nettype wire

/* hdl/key_value_slot_table_top.sv */
// Top level of the key/value slot table: command sequencer, occupied bits,
// key and value RAMs and the scan unit. Depends on kvst_pkg, kvst_ram and
// kvst_scan.
//
// Usage:
//   The request channel (req_*) carries one command per beat: req_tuser holds
//   the command (insert, pop by key, clear), req_tdata holds key and value.
//   The response channel (rsp_*) returns exactly one beat per command with
//   the ok flag, the popped value, the empty flag and the key of the lowest occupied slot.
//   Each command reads every slot's key from the key RAM, one slot per cycle
//   through a single comparator; a pop that hits then reads the value RAM
//   once more before the response beat is offered. A new command is accepted
//   at the earliest in the cycle after the response beat is taken, so the
//   block never takes a new command before the last one has been answered.
//   req_tready is high only while the block waits for a command.
//   If the receiver holds rsp_tready low, the response beat is held stable
//   and no further command is accepted until it is taken.
//   Reset clears all occupied bits at once, so the table is empty and ready
//   in the first cycle after reset; no clearing pass is needed.
`default_nettype none

module key_value_slot_table_top #(
   parameter int SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // [31:0] key, [63:32] value
   input  wire logic [1:0]  req_tuser,  // [1:0] cmd
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata   // [0] ok, [32:1] value_out, [33] empty_res,
                                        // [65:34] first_key, [71:66] zero
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_UPDATE,
      S_VREAD,
      S_RESP
   } state_type;

   state_type                    state_ff, state_in;
   kvst_pkg::cmd_type            cmd_ff, cmd_in;
   logic [kvst_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [kvst_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]             addr_ff, addr_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]             chk_idx_ff, chk_idx_in;
   logic [SLOTS-1:0]             used_ff, used_in;
   logic                         ok_ff, ok_in;
   logic [kvst_pkg::VALUE_W-1:0] vout_ff, vout_in;
   logic [kvst_pkg::KEY_W-1:0]   first_ff, first_in;

   kvst_pkg::scan_ctl_type       scan_ctl;
   logic                         key_rd_en;
   logic [kvst_pkg::KEY_W-1:0]   key_rd_data;
   logic                         tbl_wr_en;
   logic                         val_rd_en;
   logic [kvst_pkg::VALUE_W-1:0] val_rd_data;

   logic                         free_found;
   logic [IDX_W-1:0]             free_idx;
   logic                         hit_found;
   logic [IDX_W-1:0]             hit_idx;
   logic                         lo_found;
   logic [IDX_W-1:0]             lo_idx;
   logic [kvst_pkg::KEY_W-1:0]   lo_key;
   logic [kvst_pkg::KEY_W-1:0]   sec_key;
   logic                         key_nonzero;

   assign key_nonzero = (key_ff != '0);

   // Key and value storage; both are written together on a successful insert.
   kvst_ram #(
      .WIDTH (kvst_pkg::KEY_W),
      .DEPTH (SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (free_idx),
      .wr_data (key_ff),
      .rd_en   (key_rd_en),
      .rd_addr (addr_ff),
      .rd_data (key_rd_data)
   );

   kvst_ram #(
      .WIDTH (kvst_pkg::VALUE_W),
      .DEPTH (SLOTS)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (free_idx),
      .wr_data (value_ff),
      .rd_en   (val_rd_en),
      .rd_addr (hit_idx),
      .rd_data (val_rd_data)
   );

   // Scan unit sees each slot in the cycle after its key read is issued.
   assign scan_ctl.clear = req_tvalid && req_tready;
   assign scan_ctl.step  = chk_vld_ff;

   kvst_scan #(
      .SLOTS (SLOTS)
   ) u_scan (
      .clock      (clock),
      .ctl        (scan_ctl),
      .slot_idx   (chk_idx_ff),
      .slot_used  (used_ff[chk_idx_ff]),
      .slot_key   (key_rd_data),
      .req_key    (key_ff),
      .free_found (free_found),
      .free_idx   (free_idx),
      .hit_found  (hit_found),
      .hit_idx    (hit_idx),
      .lo_found   (lo_found),
      .lo_idx     (lo_idx),
      .lo_key     (lo_key),
      .sec_key    (sec_key)
   );

   // Sequencer: accept, scan all slots, apply the command, respond.
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      value_in   = value_ff;
      addr_in    = addr_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      used_in    = used_ff;
      ok_in      = ok_ff;
      vout_in    = vout_ff;
      first_in   = first_ff;
      key_rd_en  = 1'b0;
      tbl_wr_en  = 1'b0;
      val_rd_en  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = kvst_pkg::cmd_type'(req_tuser);
               key_in   = req_tdata[31:0];
               value_in = req_tdata[63:32];
               addr_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            key_rd_en  = 1'b1;
            chk_vld_in = 1'b1;
            chk_idx_in = addr_ff;
            if (addr_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            // The last slot is being compared in this cycle.
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            ok_in    = 1'b0;
            vout_in  = '0;
            first_in = lo_key;
            state_in = S_RESP;
            unique case (cmd_ff)
               kvst_pkg::CMD_INSERT: begin
                  if (key_nonzero && free_found) begin
                     tbl_wr_en         = 1'b1;
                     used_in[free_idx] = 1'b1;
                     ok_in             = 1'b1;
                     if (!(lo_found && (lo_idx < free_idx))) begin
                        first_in = key_ff;
                     end
                  end
               end
               kvst_pkg::CMD_POP: begin
                  if (key_nonzero && hit_found) begin
                     val_rd_en        = 1'b1;
                     used_in[hit_idx] = 1'b0;
                     ok_in            = 1'b1;
                     state_in         = S_VREAD;
                     if (hit_idx == lo_idx) begin
                        first_in = sec_key;
                     end
                  end
               end
               kvst_pkg::CMD_CLEAR: begin
                  used_in  = '0;
                  ok_in    = 1'b1;
                  first_in = '0;
               end
               default: begin
                  // Unused command code: nothing changes.
                  ok_in = 1'b0;
               end
            endcase
         end
         S_VREAD: begin
            vout_in  = val_rd_data;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         chk_vld_ff <= 1'b0;
         used_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         used_ff    <= used_in;
      end
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      value_ff   <= value_in;
      addr_ff    <= addr_in;
      chk_idx_ff <= chk_idx_in;
      ok_ff      <= ok_in;
      vout_ff    <= vout_in;
      first_ff   <= first_in;
   end

   // Handshake and response beat.
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {6'b0, first_ff, (first_ff == '0), vout_ff, ok_ff};

endmodule : key_value_slot_table_top

`default_nettype wire

/* hdl/kvst_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependencies.
`default_nettype none

module kvst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : kvst_ram

`default_nettype wire

/* hdl/kvst_scan.sv */
// Shared compare unit: examines one slot per cycle and keeps the lowest free
// slot, the lowest occupied slot matching the request key, and the keys of
// the two lowest occupied slots. Depends on kvst_pkg.
`default_nettype none

module kvst_scan #(
   parameter int SLOTS = 16
) (
   input  wire logic                                   clock,
   input  wire kvst_pkg::scan_ctl_type                 ctl,
   input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] slot_idx,
   input  wire logic                                   slot_used,
   input  wire logic [kvst_pkg::KEY_W-1:0]             slot_key,
   input  wire logic [kvst_pkg::KEY_W-1:0]             req_key,
   output logic                                        free_found,
   output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  free_idx,
   output logic                                        hit_found,
   output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  hit_idx,
   output logic                                        lo_found,
   output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  lo_idx,
   output logic [kvst_pkg::KEY_W-1:0]                  lo_key,
   output logic [kvst_pkg::KEY_W-1:0]                  sec_key
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic                       free_found_ff, free_found_in;
   logic [IDX_W-1:0]           free_idx_ff, free_idx_in;
   logic                       hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]           hit_idx_ff, hit_idx_in;
   logic                       lo_found_ff, lo_found_in;
   logic [IDX_W-1:0]           lo_idx_ff, lo_idx_in;
   logic [kvst_pkg::KEY_W-1:0] lo_key_ff, lo_key_in;
   logic                       sec_found_ff, sec_found_in;
   logic [kvst_pkg::KEY_W-1:0] sec_key_ff, sec_key_in;
   logic                       key_match;

   // The one key comparator of the block.
   assign key_match = (slot_key == req_key);

   // Accumulate the first hit of each kind as slots go by in ascending order.
   always_comb begin
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      lo_found_in   = lo_found_ff;
      lo_idx_in     = lo_idx_ff;
      lo_key_in     = lo_key_ff;
      sec_found_in  = sec_found_ff;
      sec_key_in    = sec_key_ff;
      if (ctl.clear) begin
         free_found_in = 1'b0;
         hit_found_in  = 1'b0;
         lo_found_in   = 1'b0;
         lo_key_in     = '0;
         sec_found_in  = 1'b0;
         sec_key_in    = '0;
      end else if (ctl.step) begin
         if (!slot_used && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = slot_idx;
         end
         if (slot_used && key_match && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = slot_idx;
         end
         if (slot_used) begin
            if (!lo_found_ff) begin
               lo_found_in = 1'b1;
               lo_idx_in   = slot_idx;
               lo_key_in   = slot_key;
            end else if (!sec_found_ff) begin
               sec_found_in = 1'b1;
               sec_key_in   = slot_key;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      lo_found_ff   <= lo_found_in;
      lo_idx_ff     <= lo_idx_in;
      lo_key_ff     <= lo_key_in;
      sec_found_ff  <= sec_found_in;
      sec_key_ff    <= sec_key_in;
   end

   assign free_found = free_found_ff;
   assign free_idx   = free_idx_ff;
   assign hit_found  = hit_found_ff;
   assign hit_idx    = hit_idx_ff;
   assign lo_found   = lo_found_ff;
   assign lo_idx     = lo_idx_ff;
   assign lo_key     = lo_key_ff;
   assign sec_key    = sec_key_ff;

endmodule : kvst_scan

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the key/value slot table top level.
// Depends on kvst_pkg and key_value_slot_table_top; reads no files.
// A scoreboard class predicts every response beat from its own slot table.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS        = 16;
   localparam int RANDOM_ITEMS = 1500;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 2 * (SLOTS + 6);

   // Command code that the package leaves unnamed; the block must ignore it.
   localparam logic [kvst_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Fields of one response beat.
   typedef struct packed {
      logic                         ok;
      logic [kvst_pkg::VALUE_W-1:0] value_out;
      logic                         empty_res;
      logic [kvst_pkg::KEY_W-1:0]   first_key;
   } table_result_type;

   // Keeps a shadow copy of the slots and the responses still owed.
   class slot_table_scoreboard;
      logic [kvst_pkg::KEY_W-1:0]   shadow_key[SLOTS];
      logic [kvst_pkg::VALUE_W-1:0] shadow_value[SLOTS];
      table_result_type             owed[$];
      int                           errors;

      function new();
         errors = 0;
         for (int i = 0; i < SLOTS; i++) begin
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // Applies one accepted command to the shadow slots and queues its response.
      function void note_request(logic [kvst_pkg::CMD_W-1:0] cmd,
                                 logic [kvst_pkg::KEY_W-1:0] key,
                                 logic [kvst_pkg::VALUE_W-1:0] value);
         table_result_type res;
         res = '0;
         case (cmd)
            kvst_pkg::CMD_INSERT: begin
               if (key != '0) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (shadow_key[i] == '0) begin
                        shadow_key[i]   = key;
                        shadow_value[i] = value;
                        res.ok          = 1'b1;
                        break;
                     end
                  end
               end
            end
            kvst_pkg::CMD_POP: begin
               if (key != '0) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (shadow_key[i] == key) begin
                        res.value_out   = shadow_value[i];
                        shadow_key[i]   = '0;
                        shadow_value[i] = '0;
                        res.ok          = 1'b1;
                        break;
                     end
                  end
               end
            end
            kvst_pkg::CMD_CLEAR: begin
               for (int i = 0; i < SLOTS; i++) begin
                  shadow_key[i]   = '0;
                  shadow_value[i] = '0;
               end
               res.ok = 1'b1;
            end
            default: begin
            end
         endcase
         // The lowest occupied slot decides first_key and the empty flag.
         res.empty_res = 1'b1;
         for (int i = 0; i < SLOTS; i++) begin
            if (shadow_key[i] != '0) begin
               res.first_key = shadow_key[i];
               res.empty_res = 1'b0;
               break;
            end
         end
         owed.push_back(res);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      // Compares one response beat with the oldest owed response.
      task check_response(logic [71:0] beat);
         table_result_type want;
         table_result_type got;
         if (owed.size() == 0) begin
            report_mismatch($sformatf("response beat %h with no command outstanding", beat));
         end else begin
            want = owed.pop_front();
            got  = '{ok: beat[0], value_out: beat[32:1], empty_res: beat[33],
                     first_key: beat[65:34]};
            if (got.ok !== want.ok)
               report_mismatch($sformatf("ok %b, want %b", got.ok, want.ok));
            if (got.value_out !== want.value_out)
               report_mismatch($sformatf("value_out %h, want %h",
                                         got.value_out, want.value_out));
            if (got.empty_res !== want.empty_res)
               report_mismatch($sformatf("empty_res %b, want %b",
                                         got.empty_res, want.empty_res));
            if (got.first_key !== want.first_key)
               report_mismatch($sformatf("first_key %h, want %h",
                                         got.first_key, want.first_key));
            if (beat[71:66] !== '0)
               report_mismatch($sformatf("pad bits %b, want zero", beat[71:66]));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [31:0] key, [63:32] value
   logic [1:0]  req_tuser;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // [0] ok, [32:1] value_out, [33] empty_res,
                             // [65:34] first_key, [71:66] zero

   slot_table_scoreboard sb;
   bit steady;          // no idling on either side while set
   bit hold_request;    // asks the response side for one long hold-off
   int idle_cycles;

   key_value_slot_table_top #(
      .SLOTS(SLOTS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Keys come mostly from a small pool so pops hit and duplicates pile up.
   function automatic logic [kvst_pkg::KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return kvst_pkg::KEY_W'($urandom_range(1, 12));
      if (r < 90) return $urandom();
      if (r < 96) return 32'hFFFF_FFFF - kvst_pkg::KEY_W'($urandom_range(0, 2));
      return '0;
   endfunction

   function automatic logic [kvst_pkg::CMD_W-1:0] pick_cmd(bit fill_phase);
      int r;
      r = $urandom_range(0, 999);
      if (r < 15) return kvst_pkg::CMD_CLEAR;
      if (r < 25) return CMD_UNUSED;
      if (fill_phase) return (r < 700) ? kvst_pkg::CMD_INSERT : kvst_pkg::CMD_POP;
      return (r < 300) ? kvst_pkg::CMD_INSERT : kvst_pkg::CMD_POP;
   endfunction

   // Offers one command beat and returns at the edge where it is taken.
   task automatic send_request(logic [kvst_pkg::CMD_W-1:0] cmd,
                               logic [kvst_pkg::KEY_W-1:0] key,
                               logic [kvst_pkg::VALUE_W-1:0] value);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {value, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, key, value);
   endtask

   // Response side: random stalls, steady stretches and one long hold-off.
   initial begin : response_sink
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_tready <= 1'b0;
         end
      end
   end

   // Ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed corner cases, then random commands.
   initial begin : stimulus
      sb           = new();
      steady       = 1'b0;
      hold_request = 1'b0;
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= kvst_pkg::CMD_INSERT;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table, key zero, duplicates, zero value and the unused code.
      send_request(kvst_pkg::CMD_POP,    32'd5,         32'd0);
      send_request(kvst_pkg::CMD_INSERT, 32'd0,         32'd7);
      send_request(kvst_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(kvst_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_1234);
      send_request(kvst_pkg::CMD_INSERT, 32'd1,         32'd0);
      send_request(kvst_pkg::CMD_POP,    32'd0,         32'hFFFF_FFFF);
      send_request(CMD_UNUSED,           32'd1,         32'd9);
      send_request(kvst_pkg::CMD_POP,    32'hFFFF_FFFF, 32'd0);
      send_request(kvst_pkg::CMD_INSERT, 32'd2,         32'd5);
      send_request(kvst_pkg::CMD_POP,    32'd1,         32'd0);
      send_request(kvst_pkg::CMD_CLEAR,  32'd0,         32'd0);
      // Fill every slot, then one insert too many.
      for (int i = 0; i <= SLOTS; i++)
         send_request(kvst_pkg::CMD_INSERT, kvst_pkg::KEY_W'(100 + i),
                      ~kvst_pkg::VALUE_W'(i));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         logic [kvst_pkg::CMD_W-1:0]   cmd;
         logic [kvst_pkg::VALUE_W-1:0] value;
         steady = (n % 250) < 40;
         if (n == 600) hold_request = 1'b1;
         cmd   = pick_cmd(((n / 120) % 2) == 0);
         value = ($urandom_range(0, 19) == 0) ? '0 : $urandom();
         send_request(cmd, pick_key(), value);
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
